// ----- rtl/core/hgp_pkg.sv -----
// hgp_pkg: shared types and constants of the hashed gaussian pair generator
// used by the channel interfaces and by hashed_gaussian_pair_top; no dependencies
package hgp_pkg;

  // output fraction bits of the signed Q3.x results
  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_W         = 20;

  typedef logic signed [15:0]      bin_index_t;
  typedef logic [2:0]              cascade_t;
  typedef logic signed [OUT_W-1:0] gauss_t;
  typedef logic [31:0]             word_t;

  // key forming multipliers
  localparam word_t KEY_MUL_X = 32'd73856093;
  localparam word_t KEY_MUL_Y = 32'd19349663;
  localparam word_t KEY_MUL_C = 32'd83492791;

  // mixer round multipliers
  localparam word_t MIX_C1 = 32'hed5ad4bb;
  localparam word_t MIX_C2 = 32'hac4c1b51;
  localparam word_t MIX_C3 = 32'h31848bab;

  // fixed point constants
  localparam logic [31:0] TWO_LN2_Q31 = 32'd2977044472;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [35:0] CLAMP_S_Q30 = 36'd34613346847;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  // taylor divisors in horner order
  localparam logic [6:0] COS_K [5] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [6:0] SIN_K [4] = '{7'd72, 7'd42, 7'd20, 7'd6};

endpackage

// ----- rtl/core/hgp_ifs.sv -----
// valid/ready channel interfaces of the hashed gaussian pair generator
// depends on hgp_pkg for payload types
interface hgp_in_if;
  import hgp_pkg::*;
  logic       valid;
  logic       ready;
  bin_index_t index_x;
  bin_index_t index_y;
  cascade_t   cascade_index;
  modport source (output valid, output index_x, output index_y, output cascade_index,
                  input ready);
  modport sink   (input valid, input index_x, input index_y, input cascade_index,
                  output ready);
endinterface

interface hgp_out_if;
  import hgp_pkg::*;
  logic   valid;
  logic   ready;
  gauss_t gauss_real;
  gauss_t gauss_imag;
  modport source (output valid, output gauss_real, output gauss_imag, input ready);
  modport sink   (input valid, input gauss_real, input gauss_imag, output ready);
endinterface

interface hgp_cfg_if;
  import hgp_pkg::*;
  logic  valid;
  logic  ready;
  word_t seed;
  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

// ----- rtl/core/hashed_gaussian_pair_top.sv -----
// hashed_gaussian_pair_top: Box-Muller gaussian pair from a hashed bin key
// depends on hgp_pkg and the channel interfaces in hgp_ifs.sv
//
// Fully pipelined: one transaction is accepted every clock while the output is
// not stalled. The pipeline depth is set by the 24-step squaring log2 (one
// squaring multiplier per stage) followed by the 27-stage bit-per-stage square
// root; the hash, the second mix round and the Taylor sine/cosine pipeline run
// alongside it. A stall on the output freezes the whole pipeline in place. The
// seed register may be written at any time the pipeline is empty; it needs no
// clearing after reset.
module hashed_gaussian_pair_top
  import hgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hgp_in_if.sink     in_if,
  hgp_out_if.source  out_if,
  hgp_cfg_if.sink    cfg_if
);

  localparam int PIPE_N  = 61;
  localparam int LOG_N   = 24;
  localparam int SQ_N    = 27;
  localparam int CD_N    = 32;
  localparam int SH      = 54 - OUT_FRAC_BITS;
  localparam logic [58:0] MAG_MAX = 59'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [58:0] RND     = 59'(64'd1 << (SH - 1));

  function automatic word_t xsh(word_t h, int unsigned n);
    return h ^ (h >> n);
  endfunction

  // pipeline control
  logic [PIPE_N-1:0] vld_r;
  logic              adv;

  assign adv         = !vld_r[PIPE_N-1] || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = vld_r[PIPE_N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_N-2:0], in_if.valid};
    end
  end

  // seed register
  word_t seed_r;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_if.valid) begin
      seed_r <= cfg_if.seed;
    end
  end

  // key and two mixer passes
  word_t sx, sy, sc, key_nxt, h1, h2;
  word_t key_r, ma_r, mb_r, mc_r, na_r, nb_r, nc_r;
  logic [23:0] c1_r, c2_nxt;

  always_comb begin
    sx      = {{16{in_if.index_x[15]}}, in_if.index_x};
    sy      = {{16{in_if.index_y[15]}}, in_if.index_y};
    sc      = {29'b0, in_if.cascade_index};
    key_nxt = (sx * KEY_MUL_X) ^ (sy * KEY_MUL_Y) ^ (sc * KEY_MUL_C) ^ seed_r;
    h1      = xsh(mc_r, 14);
    h2      = xsh(nc_r, 14);
    c2_nxt  = h2[31:8];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r <= key_nxt;
      ma_r  <= xsh(key_r, 17) * MIX_C1;
      mb_r  <= xsh(ma_r, 11) * MIX_C2;
      mc_r  <= xsh(mb_r, 15) * MIX_C3;
      c1_r  <= h1[31:8];
      na_r  <= xsh(h1, 17) * MIX_C1;
      nb_r  <= xsh(na_r, 11) * MIX_C2;
      nc_r  <= xsh(nb_r, 15) * MIX_C3;
    end
  end

  // log2 setup: leading one and normalized mantissa
  logic [4:0]  e_nxt;
  logic [53:0] mshift;
  logic [30:0] lm_r [LOG_N+1];
  logic [23:0] lf_r [LOG_N+1];
  logic [4:0]  le_r [LOG_N+1];
  logic        lc_r [LOG_N+1];

  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < 24; i++) begin
      if (c1_r[i]) e_nxt = 5'(i);
    end
    mshift = 54'(c1_r) << (5'd30 - e_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lm_r[0] <= mshift[30:0];
      lf_r[0] <= '0;
      le_r[0] <= e_nxt;
      lc_r[0] <= (c1_r < 24'd2);
    end
  end

  // log2 squaring steps, one fraction bit per stage
  for (genvar j = 1; j <= LOG_N; j++) begin : g_log
    logic [61:0] p;
    logic [31:0] ps;
    always_comb begin
      p  = 62'(lm_r[j-1]) * 62'(lm_r[j-1]);
      ps = p[61:30];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        lm_r[j] <= ps[31] ? ps[31:1] : ps[30:0];
        lf_r[j] <= {lf_r[j-1][22:0], ps[31]};
        le_r[j] <= le_r[j-1];
        lc_r[j] <= lc_r[j-1];
      end
    end
  end

  // -log2 u1 in Q24, then -2 ln u1 in Q30
  logic [28:0] len_r;
  logic        lc2_r;
  logic [60:0] sprod;
  logic [35:0] s_r;

  assign sprod = 61'(len_r) * 61'(TWO_LN2_Q31);

  always_ff @(posedge clk) begin
    if (adv) begin
      len_r <= {5'd24 - le_r[LOG_N], 24'b0} - {5'b0, lf_r[LOG_N]};
      lc2_r <= lc_r[LOG_N];
      s_r   <= lc2_r ? CLAMP_S_Q30 : sprod[60:25];
    end
  end

  // square root, one result bit per stage
  logic [53:0] sr_r [SQ_N];
  logic [26:0] rt_r [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam int B = SQ_N - 1 - i;
    logic [53:0] rem_in;
    logic [26:0] root_in;
    logic [55:0] trial;
    logic        ge;
    if (i == 0) begin : g_first
      assign rem_in  = {s_r, 18'b0};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sr_r[i-1];
      assign root_in = rt_r[i-1];
    end
    always_comb begin
      trial = (56'(root_in) << (B + 1)) | (56'd1 << (2 * B));
      ge    = 56'(rem_in) >= trial;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_r[i] <= ge ? 54'(56'(rem_in) - trial) : rem_in;
        rt_r[i] <= ge ? (root_in | (27'd1 << B)) : root_in;
      end
    end
  end

  // angle code delay to line up with the radius
  logic [23:0] cd_r [CD_N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_r[0] <= c2_nxt;
      for (int k = 1; k <= CD_N; k++) cd_r[k] <= cd_r[k-1];
    end
  end

  // octant fold and angle in radians
  logic [21:0] a_w, tr_r;
  logic        lo_w;
  logic [1:0]  tq_r [18];
  logic        tl_r [18];
  logic [53:0] xprod;
  logic [29:0] tx_r [14];
  logic [59:0] x2prod;
  logic [29:0] tx2_r [13];

  always_comb begin
    a_w    = cd_r[CD_N][21:0];
    lo_w   = !a_w[21];
    xprod  = 54'(tr_r) * 54'(PI_Q30);
    x2prod = 60'(tx_r[0]) * 60'(tx_r[0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tr_r     <= lo_w ? a_w : 22'(23'h40_0000 - 23'(a_w));
      tq_r[0]  <= cd_r[CD_N][23:22];
      tl_r[0]  <= lo_w;
      for (int k = 1; k < 18; k++) begin
        tq_r[k] <= tq_r[k-1];
        tl_r[k] <= tl_r[k-1];
      end
      tx_r[0]  <= xprod[52:23];
      for (int k = 1; k < 14; k++) tx_r[k] <= tx_r[k-1];
      tx2_r[0] <= x2prod[59:30];
      for (int k = 1; k < 13; k++) tx2_r[k] <= tx2_r[k-1];
    end
  end

  // cosine horner steps: product, reciprocal multiply, correction
  logic [29:0] cy_r [5];
  logic [29:0] cq_r [5];
  logic [29:0] cyb_r [5];
  logic [30:0] ct_r [5];

  for (genvar j = 0; j < 5; j++) begin : g_cos
    localparam logic [31:0] CM = 32'(64'h1_0000_0000 / 64'(COS_K[j]));
    logic [30:0] t_in;
    logic [60:0] yp;
    logic [61:0] qp;
    logic [36:0] rem;
    logic [29:0] q;
    if (j == 0) begin : g_first
      assign t_in = Q30_ONE;
    end else begin : g_next
      assign t_in = ct_r[j-1];
    end
    always_comb begin
      yp  = 61'(tx2_r[3*j]) * 61'(t_in);
      qp  = 62'(cy_r[j]) * 62'(CM);
      rem = 37'(cyb_r[j]) - 37'(cq_r[j]) * 37'(COS_K[j]);
      q   = cq_r[j] + 30'(rem >= 37'(COS_K[j]));
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cy_r[j]  <= yp[59:30];
        cq_r[j]  <= qp[61:32];
        cyb_r[j] <= cy_r[j];
        ct_r[j]  <= Q30_ONE - 31'(q);
      end
    end
  end

  // sine horner steps, same form
  logic [29:0] sy_r [4];
  logic [29:0] sq_r [4];
  logic [29:0] syb_r [4];
  logic [30:0] st_r [4];

  for (genvar j = 0; j < 4; j++) begin : g_sin
    localparam logic [31:0] SM = 32'(64'h1_0000_0000 / 64'(SIN_K[j]));
    logic [30:0] t_in;
    logic [60:0] yp;
    logic [61:0] qp;
    logic [36:0] rem;
    logic [29:0] q;
    if (j == 0) begin : g_first
      assign t_in = Q30_ONE;
    end else begin : g_next
      assign t_in = st_r[j-1];
    end
    always_comb begin
      yp  = 61'(tx2_r[3*j]) * 61'(t_in);
      qp  = 62'(sy_r[j]) * 62'(SM);
      rem = 37'(syb_r[j]) - 37'(sq_r[j]) * 37'(SIN_K[j]);
      q   = sq_r[j] + 30'(rem >= 37'(SIN_K[j]));
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sy_r[j]  <= yp[59:30];
        sq_r[j]  <= qp[61:32];
        syb_r[j] <= sy_r[j];
        st_r[j]  <= Q30_ONE - 31'(q);
      end
    end
  end

  // final sine multiply by x, then align with the cosine
  logic [60:0] svp;
  logic [30:0] sv_r [3];

  assign svp = 61'(tx_r[13]) * 61'(st_r[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0] <= svp[60:30];
      sv_r[1] <= sv_r[0];
      sv_r[2] <= sv_r[1];
    end
  end

  // octant swap, quadrant swap and signs
  logic [30:0] oc_re, oc_im, tre_r, tim_r;
  logic [1:0]  qd;
  logic        nre_r, nim_r;

  always_comb begin
    qd    = tq_r[17];
    oc_re = tl_r[17] ? ct_r[4] : sv_r[2];
    oc_im = tl_r[17] ? sv_r[2] : ct_r[4];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tre_r <= qd[0] ? oc_im : oc_re;
      tim_r <= qd[0] ? oc_re : oc_im;
      nre_r <= qd[0] ^ qd[1];
      nim_r <= qd[1];
    end
  end

  // radius times trig
  logic [57:0] pre_r, pim_r;
  logic        nre2_r, nim2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r  <= 58'(rt_r[SQ_N-1]) * 58'(tre_r);
      pim_r  <= 58'(rt_r[SQ_N-1]) * 58'(tim_r);
      nre2_r <= nre_r;
      nim2_r <= nim_r;
    end
  end

  // round half away from zero, saturate, apply sign
  logic [58:0]      mre, mim;
  logic [OUT_W-2:0] sre, sim;
  gauss_t           gr_nxt, gi_nxt, gr_r, gi_r;

  always_comb begin
    mre    = (59'(pre_r) + RND) >> SH;
    mim    = (59'(pim_r) + RND) >> SH;
    sre    = (mre > MAG_MAX) ? MAG_MAX[OUT_W-2:0] : mre[OUT_W-2:0];
    sim    = (mim > MAG_MAX) ? MAG_MAX[OUT_W-2:0] : mim[OUT_W-2:0];
    gr_nxt = nre2_r ? -$signed({1'b0, sre}) : $signed({1'b0, sre});
    gi_nxt = nim2_r ? -$signed({1'b0, sim}) : $signed({1'b0, sim});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gr_r <= gr_nxt;
      gi_r <= gi_nxt;
    end
  end

  assign out_if.gauss_real = gr_r;
  assign out_if.gauss_imag = gi_r;

`ifndef ASSERT_OFF
  // a stalled pipeline neither gains nor drops a transaction
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  // square root leaves a remainder no larger than twice the root
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[58] |-> (56'(sr_r[SQ_N-1]) <= {28'b0, rt_r[SQ_N-1], 1'b0}))
    else $error("square root remainder out of range");

  // folded angle stays within one octant
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[40] |-> (tr_r <= 22'h20_0000))
    else $error("octant fold out of range");

  // cosine series stays within one
  a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[57] |-> (ct_r[4] <= Q30_ONE))
    else $error("cosine above one");

  // results stay inside the saturated range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (gr_r != gauss_t'(1 << (OUT_W - 1))) &&
                     (gi_r != gauss_t'(1 << (OUT_W - 1))))
    else $error("result outside saturated range");
`endif

endmodule

// ----- sim/hashed_gaussian_pair_top_tb.sv -----
// testbench for hashed_gaussian_pair_top: directed bins, then random bins under several seeds
// depends on hgp_pkg and the channel interfaces in rtl/core/hgp_ifs.sv
module hashed_gaussian_pair_top_tb;
  import hgp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 80;   // pipeline depth is 61 stages
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    bin_index_t x;
    bin_index_t y;
    cascade_t   c;
  } bin_t;

  typedef struct packed {
    gauss_t re;
    gauss_t im;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hgp_in_if  in_if ();
  hgp_out_if out_if ();
  hgp_cfg_if cfg_if ();

  hashed_gaussian_pair_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  word_t seed_copy = '0;
  pair_t pending_pairs[$];
  int    fails = 0;
  int    cycles = 0;
  bit    gaps_on = 1'b1;
  bit    hold_req = 1'b0;
  int    hold_left = 0;

  // directed bins: extremes of each index, every cascade, zero key
  // none of these outputs can be worked out by hand, so all go through the predictor
  localparam int N_DIR = 16;
  localparam bin_t DIRECTED [N_DIR] = '{
    '{16'sh0000, 16'sh0000, 3'd0},
    '{16'sh7fff, 16'sh7fff, 3'd7},
    '{16'sh8000, 16'sh8000, 3'd0},
    '{16'shffff, 16'shffff, 3'd7},
    '{16'sh0001, 16'sh0000, 3'd0},
    '{16'sh0000, 16'sh0001, 3'd0},
    '{16'sh0000, 16'sh0000, 3'd1},
    '{16'sh0000, 16'sh0000, 3'd2},
    '{16'sh0000, 16'sh0000, 3'd4},
    '{16'sh8000, 16'sh7fff, 3'd3},
    '{16'sh7fff, 16'sh8000, 3'd5},
    '{16'shffff, 16'sh0001, 3'd6},
    '{16'sh5555, 16'shaaaa, 3'd2},
    '{16'shaaaa, 16'sh5555, 3'd5},
    '{16'sh04d2, 16'shef1f, 3'd7},
    '{16'sh8001, 16'sh7ffe, 3'd1}
  };

  // ---------------- predictor ----------------

  function automatic word_t hash_round(word_t v);
    word_t h;
    h = v;
    h = h ^ (h >> 17); h = h * 32'hed5ad4bb;
    h = h ^ (h >> 11); h = h * 32'hac4c1b51;
    h = h ^ (h >> 15); h = h * 32'h31848bab;
    h = h ^ (h >> 14);
    return h;
  endfunction

  function automatic word_t undo_shift_xor(word_t v, int sh);
    word_t r;
    r = v;
    for (int i = 0; i < 32; i++) r = v ^ (r >> sh);
    return r;
  endfunction

  function automatic word_t odd_inverse(word_t a);
    word_t r;
    r = a;
    for (int i = 0; i < 5; i++) r = r * (32'd2 - a * r);
    return r;
  endfunction

  // key that hashes to the wanted value, used to reach the tiny-u1 clamp
  function automatic word_t key_for_hash(word_t h);
    word_t k;
    k = undo_shift_xor(h, 14);
    k = k * odd_inverse(32'h31848bab);
    k = undo_shift_xor(k, 15);
    k = k * odd_inverse(32'hac4c1b51);
    k = undo_shift_xor(k, 11);
    k = k * odd_inverse(32'hed5ad4bb);
    k = undo_shift_xor(k, 17);
    return k;
  endfunction

  // -2 ln(code / 2^24) in Q30
  function automatic longint unsigned minus_two_ln(word_t code);
    int msb;
    longint unsigned mant, frac, len;
    msb = 0;
    frac = 0;
    if (code < 2) return 64'd34613346847;
    while (msb < 31 && (code >> (msb + 1)) != 0) msb++;
    mant = longint'(code) << (30 - msb);
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    len = (longint'(24 - msb) << 24) - frac;
    return (len * 64'd2977044472) >> 25;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv, rem;
    res = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // horner taylor step shared by sine and cosine
  function automatic longint unsigned horner(longint unsigned x2, longint unsigned t,
                                            int k);
    return (64'd1 << 30) - ((x2 * t) >> 30) / k;
  endfunction

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    t = horner(x2, t, 72);
    t = horner(x2, t, 42);
    t = horner(x2, t, 20);
    t = horner(x2, t, 6);
    return (x * t) >> 30;
  endfunction

  function automatic longint unsigned cosine_q30(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    t = horner(x2, t, 90);
    t = horner(x2, t, 56);
    t = horner(x2, t, 30);
    t = horner(x2, t, 12);
    t = horner(x2, t, 2);
    return t;
  endfunction

  function automatic gauss_t scale_signed(longint unsigned radius, longint unsigned trig,
                                         bit neg);
    longint unsigned mag;
    int sh;
    sh = 54 - OUT_FRAC_BITS;
    mag = (radius * trig + (64'd1 << (sh - 1))) >> sh;
    if (mag > 64'd524287) mag = 64'd524287;
    return neg ? gauss_t'(-mag) : gauss_t'(mag);
  endfunction

  function automatic pair_t gaussian_pair(bin_t b, word_t seed_val);
    word_t key, h1, c1, c2, a, r;
    logic [1:0] quad;
    longint unsigned radius, ang, sv, cv, re, im, tmp;
    bit re_neg, im_neg;
    pair_t p;
    key = (word_t'(b.x) * 32'd73856093) ^ (word_t'(b.y) * 32'd19349663)
        ^ (word_t'(b.c) * 32'd83492791) ^ seed_val;
    h1 = hash_round(key);
    c1 = h1 >> 8;
    c2 = hash_round(h1) >> 8;
    radius = int_sqrt(minus_two_ln(c1) << 18);
    quad = c2[23:22];
    a = c2 & 32'h3fffff;
    r = (a < 32'h200000) ? a : (32'h400000 - a);
    ang = (longint'(r) * 64'd3373259426) >> 23;
    sv = sine_q30(ang);
    cv = cosine_q30(ang);
    if (a < 32'h200000) begin
      re = cv; im = sv;
    end else begin
      re = sv; im = cv;
    end
    // quadrant gives the swap and the signs
    re_neg = (quad == 2'd1) || (quad == 2'd2);
    im_neg = quad[1];
    if (quad[0]) begin
      tmp = re; re = im; im = tmp;
    end
    p.re = scale_signed(radius, re, re_neg);
    p.im = scale_signed(radius, im, im_neg);
    return p;
  endfunction

  // ---------------- drivers ----------------

  task automatic send_bin(bin_t b);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.index_x       <= b.x;
    in_if.index_y       <= b.y;
    in_if.cascade_index <= b.c;
    do @(posedge clk); while (!in_if.ready);
    pending_pairs.push_back(gaussian_pair(b, seed_copy));
    @(negedge clk);
  endtask

  task automatic write_seed(word_t s);
    cfg_if.valid <= 1'b1;
    cfg_if.seed  <= s;
    do @(posedge clk); while (!cfg_if.ready);
    seed_copy = s;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic bin_index_t pick_index();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return bin_index_t'($urandom_range(2)) - 16'sd1;
      3: return bin_index_t'($urandom_range(64)) - 16'sd32;
      default: return bin_index_t'($urandom());
    endcase
  endfunction

  function automatic bin_t random_bin();
    bin_t b;
    b.x = pick_index();
    b.y = pick_index();
    b.c = cascade_t'($urandom_range(7));
    return b;
  endfunction

  // result side idling plus the long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(gaps_on && $urandom_range(99) < 18);
    end
  end

  // result checker
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result transaction: real %0d imag %0d",
               out_if.gauss_real, out_if.gauss_imag);
        fails++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_if.gauss_real !== want.re) begin
          $error("gauss_real: expected %0d, got %0d", want.re, out_if.gauss_real);
          fails++;
        end
        if (out_if.gauss_imag !== want.im) begin
          $error("gauss_imag: expected %0d, got %0d", want.im, out_if.gauss_imag);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hashed_gaussian_pair_top: mismatch");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    in_if.valid         = 1'b0;
    in_if.index_x       = '0;
    in_if.index_y       = '0;
    in_if.cascade_index = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.seed         = '0;
    out_if.ready        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; the all-zero bin under seed 0 hashes to zero (tiny u1, code 0)
    write_seed(32'h0);
    for (int i = 0; i < N_DIR; i++) send_bin(DIRECTED[i]);
    drain();

    // tiny u1 at code 1: a seed that makes the zero bin hash into 256..511
    write_seed(key_for_hash(32'h0000_0100));
    send_bin('{16'sh0000, 16'sh0000, 3'd0});
    write_seed_after_drain: begin
      drain();
      write_seed(key_for_hash(32'h0000_01ff));
      send_bin('{16'sh0000, 16'sh0000, 3'd0});
      send_bin('{16'sh0001, 16'sh0000, 3'd0});
      drain();
    end

    // random phase, all ones seed, long back-pressure on the result side
    write_seed(32'hffff_ffff);
    hold_req = 1'b1;
    for (int i = 0; i < 100; i++) send_bin(random_bin());
    drain();

    // random phase without idling on either side
    write_seed($urandom());
    gaps_on = 1'b0;
    for (int i = 0; i < 100; i++) send_bin(random_bin());
    drain();
    gaps_on = 1'b1;

    // random phase with the sender pausing until all results are back
    write_seed(32'h8000_0000);
    for (int i = 0; i < 100; i++) begin
      if (i == 50) begin
        in_if.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(negedge clk);
      end
      send_bin(random_bin());
    end
    drain();

    write_seed($urandom());
    for (int i = 0; i < 100; i++) send_bin(random_bin());
    drain();

    if (fails == 0) begin
      $display("hashed_gaussian_pair_top: match");
    end else begin
      $display("hashed_gaussian_pair_top: mismatch");
    end
    $finish;
  end

endmodule
